### hdl/mvsm_pkg.sv
`default_nettype none
package mvsm_pkg;
  localparam int NumSources = 32;
  localparam int SrcW = 5;
  localparam int PairW = 16;
  localparam int MaxActive = 16;
  localparam logic [15:0] UnityGain = 16'h8000;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_GAIN   = 3'd3,
    REQ_DEFINE = 3'd4,
    REQ_WRITE  = 3'd5
  } req_t;

  // descriptor stored in the source memory
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] length;
    logic [15:0] position;
    logic [16:0] remaining;
    logic [15:0] gain_left;
    logic [15:0] gain_right;
    logic        playing;
    logic        repeat_on;
  } desc_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  source_id;
    logic        flag_repeat;
    logic        flag_restart;
    logic [15:0] gain_left;
    logic [15:0] gain_right;
    logic [15:0] address;
    logic [16:0] length;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
  } req_item_t;

  typedef struct packed {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic        status;
    logic [4:0]  playing_count;
  } res_item_t;

  function automatic desc_t desc_reset();
    desc_t d;
    d = '0;
    d.gain_left = UnityGain;
    d.gain_right = UnityGain;
    return d;
  endfunction
endpackage
`default_nettype wire

### hdl/mvsm_if.sv
`default_nettype none
interface mvsm_req_if import mvsm_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mvsm_res_if import mvsm_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/multi_voice_stereo_sample_mixer_core.sv
`default_nettype none
// stereo sample mixer over 32 source descriptors and a 64k-pair sample memory
// req: one request item (tick, start, stop, gain, define, write sample)
// res: one result item per request: mixed frame, status, playing count
// a non-tick request passes descriptor read, modify and write back, then
// result load; no new request is taken until its result is loaded.
// a tick walks all 32 descriptors, each through descriptor read, sample
// read and update; the multiply and accumulate then drain before the
// result loads.
// one request is worked at a time; the next is accepted as soon as the
// previous result is registered, even if that result waits for res.ready.
// reset clears all descriptors (gains to unity, nothing playing) and the
// playing count; sample memory is undefined until written.
// a stalled receiver holds the result; the following request is still
// worked, but its result waits and no further request is taken until the
// held result is taken.
module multi_voice_stereo_sample_mixer_core import mvsm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mvsm_req_if.sink   req,
  mvsm_res_if.source res
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_TREAD = 7'b0001000,
    S_TWAIT = 7'b0010000,
    S_TMAC  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state;
  req_item_t  cur;
  logic [5:0] idx;      // scan index over descriptors, top bit marks done
  logic [5:0] mac_idx;
  logic       mac_en;   // sample in flight for the mac
  logic [4:0] active_count;
  logic signed [37:0] acc_l, acc_r;
  logic signed [31:0] prod_l, prod_r;
  logic       prod_en;
  logic       res_valid;
  res_item_t  res_data;
  logic       st_q;
  logic       res_load;

  logic             d_we;
  logic [SrcW-1:0]  d_waddr, d_raddr;
  desc_t            d_wdata, d_rdata;
  logic             s_we;
  logic [PairW-1:0] s_raddr;
  logic [31:0]      s_rdata;
  logic [15:0]      gl_q, gr_q;

  mvsm_desc_ram u_desc (
    .clk, .rst, .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  mvsm_sample_ram u_samp (
    .clk, .we(s_we), .waddr(cur.address), .wdata({cur.sample_right, cur.sample_left}),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // the addressed descriptor stays on the read port until it is modified
  assign d_raddr = (state == S_IDLE) ? req.data.source_id :
                   (state == S_READ || state == S_MOD) ? cur.source_id : idx[SrcW-1:0];
  assign s_raddr = d_rdata.base + d_rdata.position;
  assign s_we    = (state == S_READ) && (cur.req_type == REQ_WRITE);

  // result register loads once the previous result is gone or being taken and, for a tick, the mac drained
  assign res_load = (state == S_DONE) && (!res_valid || res.ready)
                    && ((cur.req_type != REQ_TICK) || (!prod_en && !mac_en));

  // per-request modify and tick per-entry update
  logic  st_bad;
  logic  cnt_inc, cnt_dec;
  logic  tick_use;
  always_comb begin
    d_we = 1'b0;
    d_waddr = cur.source_id;
    d_wdata = d_rdata;
    st_bad = 1'b0;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    tick_use = 1'b0;
    if (state == S_MOD) begin
      unique case (cur.req_type)
        REQ_TICK, REQ_WRITE: ;
        REQ_START: begin
          if (d_rdata.playing || active_count >= 5'(MaxActive)) st_bad = 1'b1;
          else begin
            d_we = 1'b1;
            if (cur.flag_repeat) d_wdata.repeat_on = 1'b1;
            if (cur.flag_restart) begin
              d_wdata.position = '0;
              d_wdata.remaining = d_rdata.length;
            end
            d_wdata.playing = 1'b1;
            cnt_inc = 1'b1;
          end
        end
        REQ_STOP: begin
          if (!d_rdata.playing) st_bad = 1'b1;
          else begin
            d_we = 1'b1;
            d_wdata.playing = 1'b0;
            cnt_dec = active_count != '0;
          end
        end
        REQ_GAIN: begin
          d_we = 1'b1;
          d_wdata.gain_left = cur.gain_left;
          d_wdata.gain_right = cur.gain_right;
        end
        REQ_DEFINE: begin
          if (d_rdata.playing) st_bad = 1'b1;
          else begin
            d_we = 1'b1;
            d_wdata.base = cur.address;
            d_wdata.length = cur.length;
            d_wdata.position = '0;
            d_wdata.remaining = cur.length;
            d_wdata.repeat_on = 1'b0;
            d_wdata.gain_left = UnityGain;
            d_wdata.gain_right = UnityGain;
          end
        end
        default: st_bad = 1'b1;
      endcase
    end
    if (state == S_TMAC && !mac_idx[5] && d_rdata.playing) begin
      d_waddr = mac_idx[SrcW-1:0];
      d_we = 1'b1;
      if (d_rdata.remaining != '0) begin
        tick_use = 1'b1;
        d_wdata.position = d_rdata.position + 16'd1;
        d_wdata.remaining = d_rdata.remaining - 17'd1;
      end else if (d_rdata.repeat_on) begin
        d_wdata.position = '0;
        d_wdata.remaining = d_rdata.length;
      end else begin
        d_wdata.playing = 1'b0;
        cnt_dec = active_count != '0;
      end
    end
  end

  function automatic logic signed [15:0] finish(input logic signed [37:0] a);
    logic signed [37:0] t;
    logic signed [22:0] q;
    t = a + ((a < 0) ? 38'sd32767 : 38'sd0);
    q = t[37:15];
    if (q > 23'sd32767) return 16'sd32767;
    if (q < -23'sd32767) return -16'sd32767;
    return q[15:0];
  endfunction

  // tick scan: each descriptor goes through these states in turn:
  // read desc (TREAD), desc valid and sample address out (TWAIT), sample valid (TMAC)
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      active_count <= '0;
      idx <= '0;
      mac_idx <= '0;
      prod_en <= 1'b0;
      mac_en <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res.valid && res.ready) res_valid <= 1'b0;
      if (cnt_inc) active_count <= active_count + 5'd1;
      else if (cnt_dec) active_count <= active_count - 5'd1;
      prod_en <= tick_use;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          cur <= req.data;
          state <= (req.data.req_type == REQ_TICK) ? S_TREAD : S_READ;
          idx <= '0;
          acc_l <= '0;
          acc_r <= '0;
        end
        S_READ: state <= S_MOD;
        S_MOD: begin
          st_q <= st_bad;
          state <= S_DONE;
        end
        S_TREAD: begin
          // d_raddr = idx this cycle
          mac_idx <= idx;
          state <= S_TWAIT;
        end
        S_TWAIT: state <= S_TMAC;  // desc registered; sample read issued
        S_TMAC: begin
          gl_q <= d_rdata.gain_left;
          gr_q <= d_rdata.gain_right;
          if (idx == 6'(NumSources - 1)) begin
            idx <= 6'(NumSources);
            state <= S_DONE;
          end else begin
            idx <= idx + 6'd1;
            state <= S_TREAD;
          end
        end
        S_DONE: begin
          if (res_load) begin
            if (cur.req_type == REQ_TICK) begin
              res_data.mix_left <= finish(acc_l);
              res_data.mix_right <= finish(acc_r);
              res_data.status <= 1'b0;
            end else begin
              res_data.mix_left <= '0;
              res_data.mix_right <= '0;
              res_data.status <= st_q;
            end
            res_data.playing_count <= active_count;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // multiply stage then accumulate stage
      mac_en <= prod_en;
      if (prod_en) begin
        prod_l <= $signed({1'b0, gl_q}) * $signed(s_rdata[15:0]);
        prod_r <= $signed({1'b0, gr_q}) * $signed(s_rdata[31:16]);
      end
      if (mac_en) begin
        acc_l <= acc_l + 38'(prod_l);
        acc_r <= acc_r + 38'(prod_r);
      end
    end
  end
endmodule
`default_nettype wire

### hdl/mvsm_sample_ram.sv
`default_nettype none
module mvsm_sample_ram import mvsm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [PairW-1:0] waddr,
  input  wire logic [31:0]      wdata,
  input  wire logic [PairW-1:0] raddr,
  output logic      [31:0]      rdata
);
  logic [31:0] mem [2**PairW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hdl/mvsm_desc_ram.sv
`default_nettype none
// descriptor memory with valid bits; an entry not yet written reads as reset value
module mvsm_desc_ram import mvsm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            we,
  input  wire logic [SrcW-1:0] waddr,
  input  wire desc_t           wdata,
  input  wire logic [SrcW-1:0] raddr,
  output desc_t                rdata
);
  desc_t mem [NumSources];
  logic [NumSources-1:0] vld;
  desc_t raw;
  logic  raw_vld;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    raw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      raw_vld <= 1'b0;
    end else begin
      if (we) vld[waddr] <= 1'b1;
      raw_vld <= vld[raddr];
    end
  end

  assign rdata = raw_vld ? raw : desc_reset();
endmodule
`default_nettype wire

### dv/mvsm_mix_scoreboard.sv
`timescale 1ns / 1ps
package mvsm_mix_tb_pkg;
  import mvsm_pkg::*;

  class mixer_scoreboard;
    logic [31:0] pairs [int unsigned];
    logic [15:0] base [NumSources];
    logic [16:0] len [NumSources];
    logic [15:0] pos [NumSources];
    logic [16:0] remain [NumSources];
    logic [15:0] gl [NumSources];
    logic [15:0] gr [NumSources];
    bit playing [NumSources];
    bit rep [NumSources];
    int unsigned active;
    res_item_t pending_frames [$];
    int errors;
    int checked;
    int ticks;

    function new();
      for (int i = 0; i < NumSources; i++) begin
        base[i] = '0; len[i] = '0; pos[i] = '0; remain[i] = '0;
        gl[i] = UnityGain; gr[i] = UnityGain; playing[i] = 0; rep[i] = 0;
      end
      active = 0;
      errors = 0;
      checked = 0;
      ticks = 0;
    endfunction

    function automatic logic signed [15:0] finish(longint acc);
      longint q;
      q = acc / 32768;
      if (q > 32767) q = 32767;
      if (q < -32767) q = -32767;
      return q[15:0];
    endfunction

    function void note_request(req_item_t r);
      res_item_t o;
      longint accl, accr;
      logic [31:0] w;
      int id;
      accl = 0;
      accr = 0;
      id = r.source_id;
      o = '0;
      case (r.req_type)
        REQ_TICK: begin
          ticks++;
          for (int i = 0; i < NumSources; i++) begin
            if (!playing[i]) continue;
            if (remain[i] > 0) begin
              w = pairs[16'(base[i] + pos[i])];
              accl += longint'(gl[i]) * longint'($signed(w[15:0]));
              accr += longint'(gr[i]) * longint'($signed(w[31:16]));
              pos[i] = pos[i] + 16'd1;
              remain[i] = remain[i] - 17'd1;
            end else if (rep[i]) begin
              pos[i] = '0;
              remain[i] = len[i];
            end else begin
              playing[i] = 0;
              if (active > 0) active--;
            end
          end
          o.mix_left = finish(accl);
          o.mix_right = finish(accr);
        end
        REQ_WRITE: pairs[r.address] = {r.sample_right, r.sample_left};
        REQ_START: begin
          if (playing[id] || active >= MaxActive) o.status = 1;
          else begin
            if (r.flag_repeat) rep[id] = 1;
            if (r.flag_restart) begin
              pos[id] = '0;
              remain[id] = len[id];
            end
            playing[id] = 1;
            active++;
          end
        end
        REQ_STOP: begin
          if (playing[id]) begin
            playing[id] = 0;
            if (active > 0) active--;
          end else o.status = 1;
        end
        REQ_GAIN: begin
          gl[id] = r.gain_left;
          gr[id] = r.gain_right;
        end
        REQ_DEFINE: begin
          if (playing[id]) o.status = 1;
          else begin
            base[id] = r.address; len[id] = r.length; pos[id] = '0;
            remain[id] = r.length; rep[id] = 0;
            gl[id] = UnityGain; gr[id] = UnityGain;
          end
        end
        default: o.status = 1;
      endcase
      o.playing_count = active[4:0];
      pending_frames.push_back(o);
    endfunction

    function void report(string what, int got, int want);
      $display("mismatch item %0d: %s got %0d expected %0d", checked, what, got, want);
      errors++;
    endfunction

    function void check_result(res_item_t g);
      res_item_t e;
      if (pending_frames.size() == 0) begin
        report("result with nothing pending", 1, 0);
        return;
      end
      e = pending_frames.pop_front();
      if (g.mix_left !== e.mix_left) report("mix_left", g.mix_left, e.mix_left);
      if (g.mix_right !== e.mix_right) report("mix_right", g.mix_right, e.mix_right);
      if (g.status !== e.status) report("status", g.status, e.status);
      if (g.playing_count !== e.playing_count)
        report("playing_count", g.playing_count, e.playing_count);
      checked++;
    endfunction
  endclass
endpackage

### dv/multi_voice_stereo_sample_mixer_core_tb.sv
`timescale 1ns / 1ps
module multi_voice_stereo_sample_mixer_core_tb;
  import mvsm_pkg::*;
  import mvsm_mix_tb_pkg::*;

  logic clk;
  logic rst;
  logic calm;
  int sent;
  mvsm_req_if req ();
  mvsm_res_if res ();
  mixer_scoreboard sb;

  multi_voice_stereo_sample_mixer_core DUT (.clk(clk), .rst(rst), .req(req), .res(res));

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("multi_voice_stereo_sample_mixer_core_tb: done, errors");
    $finish;
  end

  // result side: random stalls, sampled at the edge
  initial begin
    res.ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && res.valid && res.ready) sb.check_result(res.data);
      res.ready <= calm || ($urandom_range(99) >= 30);
    end
  end

  // the low 64 pairs and the top pair are written up front; random sources stay inside the low 64
  // valid stays high after an accept until the next item or an idle cycle replaces it
  task automatic send(req_item_t r);
    while (!calm && $urandom_range(99) < 30) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.data <= r;
    req.valid <= 1;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  function automatic req_item_t noise();
    req_item_t r;
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(req_item_t)-1:0];
    return r;
  endfunction

  task automatic send_op(req_t op, int id, int a, int l);
    req_item_t r;
    r = noise();
    r.req_type = op;
    r.source_id = 5'(id);
    r.address = 16'(a);
    r.length = 17'(l);
    send(r);
  endtask

  task automatic write_pair(int a, logic [15:0] sl, logic [15:0] sr);
    req_item_t r;
    r = noise();
    r.req_type = REQ_WRITE;
    r.address = 16'(a);
    r.sample_left = sl;
    r.sample_right = sr;
    send(r);
  endtask

  task automatic gain(int id, logic [15:0] l, logic [15:0] rr);
    req_item_t r;
    r = noise();
    r.req_type = REQ_GAIN;
    r.source_id = 5'(id);
    r.gain_left = l;
    r.gain_right = rr;
    send(r);
  endtask

  task automatic start(int id, bit rp, bit rs);
    req_item_t r;
    r = noise();
    r.req_type = REQ_START;
    r.source_id = 5'(id);
    r.flag_repeat = rp;
    r.flag_restart = rs;
    send(r);
  endtask

  initial begin
    req_item_t r;
    int op;
    int id;
    sb = new();
    sent = 0;
    calm = 1;
    rst = 1;
    req.valid = 0;
    req.data = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: pairs at the wrap point and the extremes
    write_pair(16'hFFFF, 16'h7FFF, 16'h8000);
    write_pair(0, 16'h8000, 16'h7FFF);
    write_pair(1, 16'h7FFF, 16'h7FFF);
    send_op(REQ_DEFINE, 0, 16'hFFFF, 3);
    gain(0, 16'hFFFF, 16'hFFFF);
    start(0, 0, 0);
    start(0, 1, 1);
    send_op(REQ_TICK, 0, 0, 0);
    send_op(REQ_TICK, 0, 0, 0);
    send_op(REQ_DEFINE, 0, 0, 1);
    send_op(REQ_TICK, 0, 0, 0);
    send_op(REQ_TICK, 0, 0, 0);
    send_op(REQ_STOP, 0, 0, 0);
    send_op(REQ_STOP, 0, 0, 0);
    send_op(REQ_DEFINE, 1, 0, 0);
    start(1, 0, 1);
    send_op(REQ_TICK, 0, 0, 0);
    send_op(REQ_TICK, 0, 0, 0);
    r = noise(); r.req_type = 3'd6; send(r);
    r = noise(); r.req_type = 3'd7; send(r);
    // fill the pool sources draw from
    for (int a = 2; a < 64; a++) write_pair(a, 16'($urandom), 16'($urandom));
    for (int i = 0; i < NumSources; i++) send_op(REQ_DEFINE, i, $urandom_range(63), 0);
    for (int i = 0; i < NumSources; i++) start(i, 1, 0);
    send_op(REQ_TICK, 0, 0, 0);
    for (int i = 0; i < NumSources; i++) send_op(REQ_STOP, i, 0, 0);
    calm = 0;
    for (int n = 0; n < 1070; n++) begin
      calm = (n >= 500 && n < 650);
      id = $urandom_range(31);
      op = $urandom_range(99);
      // lengths chosen so base+len stays within the written pool
      if (op < 35) send_op(REQ_TICK, id, $urandom, $urandom);
      else if (op < 50) start(id, 1'($urandom), 1'($urandom));
      else if (op < 58) send_op(REQ_STOP, id, 0, 0);
      else if (op < 68) gain(id, 16'($urandom), 16'($urandom));
      else if (op < 80) begin
        int b;
        b = $urandom_range(60);
        send_op(REQ_DEFINE, id, b, $urandom_range(64 - b));
      end else if (op < 95) write_pair($urandom_range(63), 16'($urandom), 16'($urandom));
      else if (op < 97) write_pair($urandom_range(65535, 64), 16'($urandom), 16'($urandom));
      else begin
        r = noise(); r.req_type = 3'(6 + $urandom_range(1)); send(r);
      end
    end
    req.valid <= 0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d requests, %0d ticks, %0d results checked", sent, sb.ticks, sb.checked);
    if (sb.errors == 0 && sb.pending_frames.size() == 0)
      $display("multi_voice_stereo_sample_mixer_core_tb: done, clean");
    else
      $display("multi_voice_stereo_sample_mixer_core_tb: done, errors");
    $finish;
  end
endmodule

### multi_voice_stereo_sample_mixer_core.f
hdl/mvsm_pkg.sv
hdl/mvsm_if.sv
hdl/mvsm_sample_ram.sv
hdl/mvsm_desc_ram.sv
hdl/multi_voice_stereo_sample_mixer_core.sv
dv/mvsm_mix_scoreboard.sv
dv/multi_voice_stereo_sample_mixer_core_tb.sv
